// ===== sv/assert_macros.svh =====
// Assertion macros used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define ASSERT_CLKD(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/pmt_pkg.sv =====
// Types, opcodes and helpers for the 65816 predecode and mode tracker.
package pmt_pkg;

  typedef enum logic [2:0] {
    KIND_PLAIN  = 3'd0,
    KIND_COND   = 3'd1,
    KIND_JUMP   = 3'd2,
    KIND_CALL   = 3'd3,
    KIND_ICALL  = 3'd4,
    KIND_IJUMP  = 3'd5,
    KIND_RETURN = 3'd6,
    KIND_STOP   = 3'd7
  } flow_kind_t;

  localparam logic [7:0] OP_BPL      = 8'h10;
  localparam logic [7:0] OP_BMI      = 8'h30;
  localparam logic [7:0] OP_BVC      = 8'h50;
  localparam logic [7:0] OP_BVS      = 8'h70;
  localparam logic [7:0] OP_BCC      = 8'h90;
  localparam logic [7:0] OP_BCS      = 8'hb0;
  localparam logic [7:0] OP_BNE      = 8'hd0;
  localparam logic [7:0] OP_BEQ      = 8'hf0;
  localparam logic [7:0] OP_BRA      = 8'h80;
  localparam logic [7:0] OP_BRL      = 8'h82;
  localparam logic [7:0] OP_JMP_ABS  = 8'h4c;
  localparam logic [7:0] OP_JML      = 8'h5c;
  localparam logic [7:0] OP_JSR      = 8'h20;
  localparam logic [7:0] OP_JSL      = 8'h22;
  localparam logic [7:0] OP_JSR_INDX = 8'hfc;
  localparam logic [7:0] OP_JMP_IND  = 8'h6c;
  localparam logic [7:0] OP_JMP_INDX = 8'h7c;
  localparam logic [7:0] OP_JML_IND  = 8'hdc;
  localparam logic [7:0] OP_RTS      = 8'h60;
  localparam logic [7:0] OP_RTL      = 8'h6b;
  localparam logic [7:0] OP_BRK      = 8'h00;
  localparam logic [7:0] OP_COP      = 8'h02;
  localparam logic [7:0] OP_RTI      = 8'h40;
  localparam logic [7:0] OP_WAI      = 8'hcb;
  localparam logic [7:0] OP_STP      = 8'hdb;
  localparam logic [7:0] OP_CLC      = 8'h18;
  localparam logic [7:0] OP_SEC      = 8'h38;
  localparam logic [7:0] OP_REP      = 8'hc2;
  localparam logic [7:0] OP_SEP      = 8'he2;
  localparam logic [7:0] OP_XCE      = 8'hfb;

  localparam logic [1:0] MAP_NONE     = 2'd0;
  localparam logic [1:0] MAP_RESET    = 2'd1;
  localparam logic [15:0] ROM_OFFSET_BASE = 16'h8000;
  localparam logic [6:0]  ROM_BANK_BASE   = 7'h40;

  // ROM region test: upper half of any bank, or the high banks (mirror bit ignored).
  function automatic logic addr_in_rom(input logic [1:0] map, input logic [23:0] addr);
    addr_in_rom = (map != MAP_NONE) &&
                  ((addr[15:0] >= ROM_OFFSET_BASE) || (addr[22:16] >= ROM_BANK_BASE));
  endfunction

endpackage

// ===== sv/pmt_cfg_if.sv =====
// Configuration write channel: map type.
interface pmt_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/pmt_instr_if.sv =====
// Instruction channel: one decoded-length instruction per transaction.
interface pmt_instr_if;
  logic        valid;
  logic        ready;
  logic [23:0] instruction_address;
  logic [7:0]  opcode;
  logic [7:0]  operand_first;
  logic [7:0]  operand_second;
  logic [7:0]  operand_third;
  logic [2:0]  length;

  modport source (output valid, output instruction_address, output opcode,
                  output operand_first, output operand_second, output operand_third,
                  output length, input ready);
  modport sink   (input valid, input instruction_address, input opcode,
                  input operand_first, input operand_second, input operand_third,
                  input length, output ready);
endinterface

// ===== sv/pmt_result_if.sv =====
// Result channel: flow info and tracked flags for one instruction.
interface pmt_result_if;
  logic        valid;
  logic        ready;
  logic [23:0] fallthrough_address;
  logic [23:0] target_address;
  logic [2:0]  flow_kind;
  logic        fallthrough_in_rom;
  logic        target_in_rom;
  logic [47:0] return_frame;
  logic        emulation_out;
  logic        accumulator_narrow;
  logic        index_narrow;
  logic        carry_out;
  logic        carry_known_out;

  modport source (output valid, output fallthrough_address, output target_address,
                  output flow_kind, output fallthrough_in_rom, output target_in_rom,
                  output return_frame, output emulation_out, output accumulator_narrow,
                  output index_narrow, output carry_out, output carry_known_out,
                  input ready);
  modport sink   (input valid, input fallthrough_address, input target_address,
                  input flow_kind, input fallthrough_in_rom, input target_in_rom,
                  input return_frame, input emulation_out, input accumulator_narrow,
                  input index_narrow, input carry_out, input carry_known_out,
                  output ready);
endinterface

// ===== sv/cpu_flow_predecode_mode_tracker.sv =====
// Top level: 65816 control-flow predecode with processor mode flag tracking.
//
//   channel | dir | carries
//   --------+-----+--------------------------------------------------
//   cfg     | in  | rom_map_type write, always ready
//   instr   | in  | address, opcode, three operand bytes, length
//   result  | out | fallthrough, target, kind, ROM hits, frame, flags
//
// Two register stages: the instruction register, then the result register.
// A result is registered as its instruction leaves the instruction register; one
// instruction per cycle runs while result.ready is high; flag update is few gates.
// Synchronous reset empties both stages and sets E, M, X, carry-known, map 1.
// A stalled result holds; the instruction register keeps filling behind it, and
// instr.ready drops only when both stages are full and result.ready is low.
module cpu_flow_predecode_mode_tracker (
  input  logic         clk,
  input  logic         rst,
  pmt_cfg_if.sink      cfg,
  pmt_instr_if.sink    instr,
  pmt_result_if.source result
);
  import pmt_pkg::*;
  `include "assert_macros.svh"

  // map type
  logic [1:0] rom_map_type;

  // tracked processor flags
  logic emulation_flag, memory_width_flag, index_width_flag, carry_flag, carry_valid;
  logic emulation_next, memory_width_next, index_width_next, carry_next, carry_valid_next;

  // instruction register
  logic        s1_valid;
  logic [23:0] s1_addr;
  logic [7:0]  s1_op, s1_b1, s1_b2, s1_b3;
  logic [2:0]  s1_len;

  logic advance;
  logic accept;

  // decode of the registered instruction
  logic [7:0]  bank;
  logic [15:0] off;
  logic [15:0] w16;
  logic [23:0] fall, rel8, rel16, abs16, lng;
  logic [23:0] target;
  flow_kind_t  kind;
  logic        has_target, follow;

  assign cfg.ready   = 1'b1;
  assign advance     = s1_valid && (!result.valid || result.ready);
  assign instr.ready = !s1_valid || advance;
  assign accept      = instr.valid && instr.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rom_map_type <= MAP_RESET;
    end else if (cfg.valid) begin
      rom_map_type <= cfg.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_addr <= instr.instruction_address;
      s1_op   <= instr.opcode;
      s1_b1   <= instr.operand_first;
      s1_b2   <= instr.operand_second;
      s1_b3   <= instr.operand_third;
      s1_len  <= instr.length;
    end
  end

  always_comb begin
    bank  = s1_addr[23:16];
    off   = s1_addr[15:0];
    w16   = {s1_b2, s1_b1};
    fall  = {bank, off + {13'd0, s1_len}};
    rel8  = {bank, off + 16'd2 + {{8{s1_b1[7]}}, s1_b1}};
    rel16 = {bank, off + 16'd3 + w16};
    abs16 = {bank, w16};
    lng   = {s1_b3, w16};
  end

  always_comb begin
    kind       = KIND_PLAIN;
    target     = '0;
    has_target = 1'b0;
    follow     = 1'b1;
    case (s1_op)
      OP_BPL, OP_BMI, OP_BVC, OP_BVS, OP_BCC, OP_BCS, OP_BNE, OP_BEQ: begin
        kind = KIND_COND; target = rel8; has_target = 1'b1;
      end
      OP_BRA: begin
        kind = KIND_JUMP; target = rel8; has_target = 1'b1; follow = 1'b0;
      end
      OP_BRL: begin
        kind = KIND_JUMP; target = rel16; has_target = 1'b1; follow = 1'b0;
      end
      OP_JMP_ABS: begin
        kind = KIND_JUMP; target = abs16; has_target = 1'b1; follow = 1'b0;
      end
      OP_JML: begin
        kind = KIND_JUMP; target = lng; has_target = 1'b1; follow = 1'b0;
      end
      OP_JSR: begin
        kind = KIND_CALL; target = abs16; has_target = 1'b1;
      end
      OP_JSL: begin
        kind = KIND_CALL; target = lng; has_target = 1'b1;
      end
      OP_JSR_INDX: begin
        kind = KIND_ICALL;
      end
      OP_JMP_IND, OP_JMP_INDX, OP_JML_IND: begin
        kind = KIND_IJUMP; follow = 1'b0;
      end
      OP_RTS, OP_RTL: begin
        kind = KIND_RETURN; follow = 1'b0;
      end
      OP_BRK, OP_COP, OP_RTI, OP_WAI, OP_STP: begin
        kind = KIND_STOP; follow = 1'b0;
      end
      default: begin
        kind = KIND_PLAIN;
      end
    endcase
  end

  // flag update for the instruction leaving the instruction register
  always_comb begin
    emulation_next    = emulation_flag;
    memory_width_next = memory_width_flag;
    index_width_next  = index_width_flag;
    carry_next        = carry_flag;
    carry_valid_next  = carry_valid;
    case (s1_op)
      OP_CLC: begin
        carry_next = 1'b0; carry_valid_next = 1'b1;
      end
      OP_SEC: begin
        carry_next = 1'b1; carry_valid_next = 1'b1;
      end
      OP_REP: begin
        if (s1_len > 3'd1) begin
          if (s1_b1[5]) memory_width_next = 1'b0;
          if (s1_b1[4]) index_width_next  = 1'b0;
          // emulation mode forces 8-bit registers
          if (emulation_flag) begin
            memory_width_next = 1'b1;
            index_width_next  = 1'b1;
          end
        end
      end
      OP_SEP: begin
        if (s1_len > 3'd1) begin
          if (s1_b1[5]) memory_width_next = 1'b1;
          if (s1_b1[4]) index_width_next  = 1'b1;
        end
      end
      OP_XCE: begin
        if (carry_valid) begin
          emulation_next = carry_flag;
          carry_next     = emulation_flag;
          if (carry_flag) begin
            memory_width_next = 1'b1;
            index_width_next  = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      emulation_flag    <= 1'b1;
      memory_width_flag <= 1'b1;
      index_width_flag  <= 1'b1;
      carry_flag        <= 1'b0;
      carry_valid       <= 1'b1;
    end else if (advance) begin
      emulation_flag    <= emulation_next;
      memory_width_flag <= memory_width_next;
      index_width_flag  <= index_width_next;
      carry_flag        <= carry_next;
      carry_valid       <= carry_valid_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (advance) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.fallthrough_address <= fall;
      result.target_address      <= target;
      result.flow_kind           <= kind;
      result.fallthrough_in_rom  <= follow && addr_in_rom(rom_map_type, fall);
      result.target_in_rom       <= has_target && addr_in_rom(rom_map_type, target);
      result.return_frame        <= (kind == KIND_CALL) ? {s1_addr, fall} : 48'd0;
      result.emulation_out       <= emulation_next;
      result.accumulator_narrow  <= memory_width_next;
      result.index_narrow        <= index_width_next;
      result.carry_out           <= carry_next;
      result.carry_known_out     <= carry_valid_next;
    end
  end

  `ASSERT_ALWAYS(a_emul_forces_narrow, clk,
    emulation_flag |-> (memory_width_flag && index_width_flag),
    "emulation mode with a 16-bit width flag")
  `ASSERT_CLKD(a_held_instr_kept, clk, rst,
    (s1_valid && !advance) |=> s1_valid,
    "stalled instruction register lost its transaction")
  `ASSERT_CLKD(a_frame_only_for_call, clk, rst,
    (result.valid && (result.flow_kind != KIND_CALL)) |-> (result.return_frame == 48'd0),
    "return frame on a non-call transaction")
  `ASSERT_CLKD(a_no_follow_rom, clk, rst,
    (result.valid && (result.flow_kind == KIND_JUMP || result.flow_kind == KIND_IJUMP ||
      result.flow_kind == KIND_RETURN || result.flow_kind == KIND_STOP))
      |-> !result.fallthrough_in_rom,
    "fallthrough flagged in ROM for a kind that does not fall through")

endmodule
